// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/htld_pkg.sv =====
package htld_pkg;

   // fixed field widths
   localparam int SYM_BITS      = 8;
   localparam int CSR_DATA_BITS = 32;
   localparam int PADDR_BITS    = 3;
   localparam int REG_SEL_BITS  = PADDR_BITS - 2;

   // register map
   localparam logic [REG_SEL_BITS-1:0] REG_SYMBOL_COUNT = 1'b0;

   // default sizes
   localparam int DEF_NODE_DEPTH  = 512;
   localparam int DEF_STACK_DEPTH = 256;
   localparam int DEF_COUNT_BITS  = 32;

   // one result transaction
   typedef struct packed {
      logic [SYM_BITS-1:0] symbol;
      logic                last;
      logic                status;
   } htld_rsp_type;

   // result hand-off from the core to the output buffer
   typedef struct packed {
      logic         push;
      htld_rsp_type data;
   } htld_enq_type;

endpackage

// ===== sv/huffman_tree_load_decoder.sv =====
// Huffman decoder that first rebuilds its code tree from a pre-order dump and then
// decodes the rest of the stream, one code bit per req transaction. In the dump a 1 is an
// internal node and a 0 is a leaf followed by 8 symbol bits, MSB first; after that a 1
// goes right and a 0 goes left, and each leaf reached returns one rsp transaction with
// the byte, last set on the byte that completes symbol_count. A node table or stack
// overflow returns one transaction with status 1, after which bits are taken and dropped
// until symbol_count is written again, as they are once the count is reached. Writing
// symbol_count (offset 0) rearms tree loading. Each bit has an accept cycle and a follow-up
// cycle: the node table and the pending stack are synchronous memories with a registered
// read, and the follow-up cycle holds the node table read of the walk, or the right-child
// link write and stack read of the load. No clearing pass follows reset. Results go through
// a two-entry output buffer, so the next bit is taken while a result still waits.
module huffman_tree_load_decoder #(
   parameter int NODE_DEPTH  = htld_pkg::DEF_NODE_DEPTH,
   parameter int STACK_DEPTH = htld_pkg::DEF_STACK_DEPTH,
   parameter int COUNT_BITS  = htld_pkg::DEF_COUNT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_code_bit,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [htld_pkg::SYM_BITS-1:0]      rsp_symbol,
   output logic                               rsp_last,
   output logic                               rsp_status,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [htld_pkg::PADDR_BITS-1:0]    csr_paddr,
   input  logic [htld_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [htld_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import htld_pkg::*;

   logic [CSR_DATA_BITS-1:0] symbol_count_ff;
   logic                     reg_sel;
   logic                     rearm;
   logic                     space_ok;
   htld_enq_type             enq;
   htld_rsp_type             rsp_data;

   // register access
   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[PADDR_BITS-1:2] == REG_SYMBOL_COUNT);
   assign rearm      = csr_psel && csr_penable && csr_pwrite && reg_sel;
   assign csr_prdata = reg_sel ? symbol_count_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= '0;
      end else if (rearm) begin
         symbol_count_ff <= csr_pwdata;
      end
   end

   htld_core #(
      .NODE_DEPTH  (NODE_DEPTH),
      .STACK_DEPTH (STACK_DEPTH),
      .COUNT_BITS  (COUNT_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .rearm        (rearm),
      .symbol_count (symbol_count_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_code_bit (req_code_bit),
      .space_ok     (space_ok),
      .enq          (enq)
   );

   htld_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .enq       (enq),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .space_ok  (space_ok)
   );

   assign rsp_symbol = rsp_data.symbol;
   assign rsp_last   = rsp_data.last;
   assign rsp_status = rsp_data.status;

endmodule

// ===== sv/htld_rsp_buf.sv =====
module htld_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  htld_pkg::htld_enq_type enq,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output htld_pkg::htld_rsp_type rsp_data,
   output logic                  space_ok
);
   import htld_pkg::*;

   localparam logic [1:0] BUF_EMPTY = 2'd0;
   localparam logic [1:0] BUF_ONE   = 2'd1;
   localparam logic [1:0] BUF_FULL  = 2'd2;

   logic [1:0]   count_ff, count_in;
   htld_rsp_type head_ff, head_in;
   htld_rsp_type skid_ff, skid_in;
   logic         deq;

   assign deq       = (count_ff != BUF_EMPTY) && rsp_ready;
   assign rsp_valid = (count_ff != BUF_EMPTY);
   assign rsp_data  = head_ff;
   // one more transaction may start if a slot is free once this edge passes
   assign space_ok  = (count_ff != BUF_FULL) || rsp_ready;

   // two-entry queue: head register plus skid register
   always_comb begin
      count_in = count_ff + {1'b0, enq.push} - {1'b0, deq};
      head_in  = head_ff;
      skid_in  = skid_ff;
      case (count_ff)
         BUF_EMPTY: begin
            if (enq.push) head_in = enq.data;
         end
         BUF_ONE: begin
            if (deq) begin
               if (enq.push) head_in = enq.data;
            end else if (enq.push) begin
               skid_in = enq.data;
            end
         end
         default: begin
            if (deq) begin
               head_in = skid_ff;
               if (enq.push) skid_in = enq.data;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= BUF_EMPTY;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== sv/htld_core.sv =====
module htld_core #(
   parameter int NODE_DEPTH  = htld_pkg::DEF_NODE_DEPTH,
   parameter int STACK_DEPTH = htld_pkg::DEF_STACK_DEPTH,
   parameter int COUNT_BITS  = htld_pkg::DEF_COUNT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rearm,
   input  logic [htld_pkg::CSR_DATA_BITS-1:0] symbol_count,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_code_bit,
   input  logic                               space_ok,
   output htld_pkg::htld_enq_type             enq
);
   import htld_pkg::*;

   localparam int IDX_BITS   = $clog2(NODE_DEPTH);
   localparam int NF_BITS    = $clog2(NODE_DEPTH + 1);
   localparam int SI_BITS    = $clog2(STACK_DEPTH);
   localparam int ST_BITS    = $clog2(STACK_DEPTH + 1);
   localparam int LB_BITS    = $clog2(SYM_BITS + 1);
   localparam int CMP_BITS   = (COUNT_BITS > CSR_DATA_BITS) ? COUNT_BITS : CSR_DATA_BITS;
   localparam int ENTRY_BITS = 1 + IDX_BITS + SYM_BITS;
   localparam int RIGHT_LSB  = SYM_BITS;
   localparam int GROUP_POS  = ENTRY_BITS - 1;

   // walk phases
   localparam logic [1:0] PH_LOAD   = 2'd0;
   localparam logic [1:0] PH_DECODE = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;
   localparam logic [1:0] PH_HALT   = 2'd3;

   // transaction slot: accept cycle, then a follow-up cycle
   localparam logic SLOT_IDLE = 1'b0;
   localparam logic SLOT_BUSY = 1'b1;

   // node table: group flag, right child, symbol (left child is index + 1)
   logic [ENTRY_BITS-1:0] node_mem [NODE_DEPTH];
   // internal nodes still waiting for their right child
   logic [IDX_BITS-1:0]   stack_mem [STACK_DEPTH];

   logic                  slot_ff, slot_in;
   logic [1:0]            phase_ff, phase_in;
   logic [ST_BITS-1:0]    stack_top_ff, stack_top_in;
   logic [NF_BITS-1:0]    next_free_ff, next_free_in;
   logic [LB_BITS-1:0]    leaf_left_ff, leaf_left_in;
   logic [SYM_BITS-1:0]   shift_ff, shift_in;
   logic [IDX_BITS-1:0]   cur_idx_ff, cur_idx_in;
   logic                  at_root_ff, at_root_in;
   logic                  cur_group_ff, cur_group_in;
   logic [IDX_BITS-1:0]   cur_right_ff, cur_right_in;
   logic                  root_group_ff, root_group_in;
   logic [IDX_BITS-1:0]   root_right_ff, root_right_in;
   logic [SYM_BITS-1:0]   root_sym_ff, root_sym_in;
   logic [IDX_BITS-1:0]   top_idx_ff, top_idx_in;
   logic [COUNT_BITS-1:0] decoded_ff, decoded_in;
   logic                  pend_right_ff, pend_right_in;
   logic [IDX_BITS-1:0]   pend_addr_ff, pend_addr_in;
   logic [IDX_BITS-1:0]   pend_val_ff, pend_val_in;
   logic                  reload_top_ff, reload_top_in;
   logic                  walk_ff, walk_in;
   logic                  direct_ff, direct_in;
   logic [IDX_BITS-1:0]   nxt_idx_ff, nxt_idx_in;
   logic [ENTRY_BITS-1:0] node_q_ff;
   logic [IDX_BITS-1:0]   stack_q_ff;

   logic                  accept;
   logic                  wr_group, wr_right, wr_sym;
   logic [IDX_BITS-1:0]   wr_addr;
   logic                  wr_group_val;
   logic [IDX_BITS-1:0]   wr_right_val;
   logic [SYM_BITS-1:0]   wr_sym_val;
   logic                  st_we;
   logic [SI_BITS-1:0]    st_waddr;
   logic [ST_BITS-1:0]    st_below;
   logic [SI_BITS-1:0]    st_raddr;
   logic [IDX_BITS-1:0]   rd_addr;
   logic                  eff_group;
   logic [IDX_BITS-1:0]   eff_right;
   logic                  ent_group;
   logic [IDX_BITS-1:0]   ent_right;
   logic [SYM_BITS-1:0]   ent_sym;
   logic [IDX_BITS-1:0]   new_idx;
   logic                  pop;
   logic [ST_BITS-1:0]    after_pop;
   logic [COUNT_BITS-1:0] decoded_inc;
   logic                  push;
   htld_rsp_type          push_data;

   function automatic logic count_hit(input logic [COUNT_BITS-1:0] cnt,
                                      input logic [CSR_DATA_BITS-1:0] target);
      count_hit = (CMP_BITS'(cnt) == CMP_BITS'(target));
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = (slot_ff == SLOT_IDLE) && space_ok;

   assign new_idx     = next_free_ff[IDX_BITS-1:0];
   assign st_below    = stack_top_ff - ST_BITS'(2);
   assign st_raddr    = st_below[SI_BITS-1:0];
   assign decoded_inc = decoded_ff + 1'b1;

   // the node the walk stands on, root held in registers
   assign eff_group = at_root_ff ? root_group_ff : cur_group_ff;
   assign eff_right = at_root_ff ? root_right_ff : cur_right_ff;
   assign rd_addr   = req_code_bit ? eff_right : cur_idx_ff + 1'b1;

   // entry seen in the follow-up cycle of a decode transaction
   assign ent_group = direct_ff ? root_group_ff : node_q_ff[GROUP_POS];
   assign ent_right = direct_ff ? root_right_ff : node_q_ff[RIGHT_LSB +: IDX_BITS];
   assign ent_sym   = direct_ff ? root_sym_ff   : node_q_ff[SYM_BITS-1:0];

   always_comb begin
      slot_in       = slot_ff;
      phase_in      = phase_ff;
      stack_top_in  = stack_top_ff;
      next_free_in  = next_free_ff;
      leaf_left_in  = leaf_left_ff;
      shift_in      = shift_ff;
      cur_idx_in    = cur_idx_ff;
      at_root_in    = at_root_ff;
      cur_group_in  = cur_group_ff;
      cur_right_in  = cur_right_ff;
      top_idx_in    = top_idx_ff;
      decoded_in    = decoded_ff;
      pend_right_in = pend_right_ff;
      pend_addr_in  = pend_addr_ff;
      pend_val_in   = pend_val_ff;
      reload_top_in = reload_top_ff;
      walk_in       = walk_ff;
      direct_in     = direct_ff;
      nxt_idx_in    = nxt_idx_ff;
      wr_group      = 1'b0;
      wr_right      = 1'b0;
      wr_sym        = 1'b0;
      wr_addr       = cur_idx_ff;
      wr_group_val  = req_code_bit;
      wr_right_val  = pend_val_ff;
      wr_sym_val    = shift_in;
      st_we         = 1'b0;
      st_waddr      = '0;
      pop           = 1'b0;
      after_pop     = stack_top_ff;
      push          = 1'b0;
      push_data     = '0;

      if (accept) begin
         slot_in = SLOT_BUSY;
         case (phase_ff)
            // tree loading from the pre-order dump
            PH_LOAD: begin
               if (leaf_left_ff != '0) begin
                  shift_in     = {shift_ff[SYM_BITS-2:0], req_code_bit};
                  leaf_left_in = leaf_left_ff - 1'b1;
                  if (leaf_left_ff == LB_BITS'(1)) begin
                     wr_sym     = 1'b1;
                     wr_addr    = cur_idx_ff;
                     wr_sym_val = shift_in;
                     if (stack_top_ff == '0) begin
                        cur_idx_in = '0;
                        at_root_in = 1'b1;
                        phase_in   = count_hit(decoded_ff, symbol_count) ? PH_DONE : PH_DECODE;
                     end
                  end
               end else if ((next_free_ff == NF_BITS'(NODE_DEPTH)) ||
                            (req_code_bit && (stack_top_ff == ST_BITS'(STACK_DEPTH)))) begin
                  // overflow of node table or stack
                  push             = 1'b1;
                  push_data.status = 1'b1;
                  phase_in         = PH_HALT;
               end else begin
                  next_free_in = next_free_ff + 1'b1;
                  wr_group     = 1'b1;
                  wr_addr      = new_idx;
                  wr_group_val = req_code_bit;
                  // left child is implicit; a parent that already has one gets a right child
                  if ((stack_top_ff != '0) &&
                      ((NF_BITS'(top_idx_ff) + 1'b1) != next_free_ff)) begin
                     pop           = 1'b1;
                     pend_right_in = 1'b1;
                     pend_addr_in  = top_idx_ff;
                     pend_val_in   = new_idx;
                  end
                  after_pop = stack_top_ff - ST_BITS'(pop);
                  if (req_code_bit) begin
                     st_we        = 1'b1;
                     st_waddr     = after_pop[SI_BITS-1:0];
                     stack_top_in = after_pop + 1'b1;
                     top_idx_in   = new_idx;
                  end else begin
                     stack_top_in  = after_pop;
                     reload_top_in = pop;
                     cur_idx_in    = new_idx;
                     shift_in      = '0;
                     leaf_left_in  = LB_BITS'(SYM_BITS);
                  end
               end
            end
            // tree walk: node table read issued now, used next cycle
            PH_DECODE: begin
               walk_in    = 1'b1;
               direct_in  = !eff_group;
               nxt_idx_in = rd_addr;
            end
            default: begin
            end
         endcase
      end

      if (slot_ff == SLOT_BUSY) begin
         slot_in = SLOT_IDLE;
         // deferred right-child link
         if (pend_right_ff) begin
            wr_right      = 1'b1;
            wr_addr       = pend_addr_ff;
            wr_right_val  = pend_val_ff;
            pend_right_in = 1'b0;
         end
         // new stack top after a pop
         if (reload_top_ff) begin
            top_idx_in    = stack_q_ff;
            reload_top_in = 1'b0;
         end
         // finish the walk step
         if (walk_ff) begin
            walk_in = 1'b0;
            if (ent_group) begin
               cur_idx_in   = nxt_idx_ff;
               cur_group_in = 1'b1;
               cur_right_in = ent_right;
               at_root_in   = 1'b0;
            end else begin
               push             = 1'b1;
               push_data.symbol = ent_sym;
               push_data.last   = count_hit(decoded_inc, symbol_count);
               decoded_in       = decoded_inc;
               if (push_data.last) phase_in = PH_DONE;
               cur_idx_in = '0;
               at_root_in = 1'b1;
            end
         end
      end
   end

   // root copy follows every write to node 0
   always_comb begin
      root_group_in = root_group_ff;
      root_right_in = root_right_ff;
      root_sym_in   = root_sym_ff;
      if (wr_addr == '0) begin
         if (wr_group) root_group_in = wr_group_val;
         if (wr_right) root_right_in = wr_right_val;
         if (wr_sym)   root_sym_in   = wr_sym_val;
      end
   end

   assign enq.push = push;
   assign enq.data = push_data;

   // node table memory
   always_ff @(posedge clock) begin
      if (wr_group) node_mem[wr_addr][GROUP_POS] <= wr_group_val;
      if (wr_right) node_mem[wr_addr][RIGHT_LSB +: IDX_BITS] <= wr_right_val;
      if (wr_sym)   node_mem[wr_addr][SYM_BITS-1:0] <= wr_sym_val;
      node_q_ff <= node_mem[rd_addr];
   end

   // pending stack memory
   always_ff @(posedge clock) begin
      if (st_we) stack_mem[st_waddr] <= new_idx;
      stack_q_ff <= stack_mem[st_raddr];
   end

   // slot sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= SLOT_IDLE;
      end else begin
         slot_ff <= slot_in;
      end
   end

   // control state, cleared by reset and by a symbol_count write
   always_ff @(posedge clock) begin
      if (reset || rearm) begin
         phase_ff      <= PH_LOAD;
         stack_top_ff  <= '0;
         next_free_ff  <= '0;
         leaf_left_ff  <= '0;
         shift_ff      <= '0;
         cur_idx_ff    <= '0;
         at_root_ff    <= 1'b1;
         decoded_ff    <= '0;
         pend_right_ff <= 1'b0;
         reload_top_ff <= 1'b0;
         walk_ff       <= 1'b0;
         direct_ff     <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         stack_top_ff  <= stack_top_in;
         next_free_ff  <= next_free_in;
         leaf_left_ff  <= leaf_left_in;
         shift_ff      <= shift_in;
         cur_idx_ff    <= cur_idx_in;
         at_root_ff    <= at_root_in;
         decoded_ff    <= decoded_in;
         pend_right_ff <= pend_right_in;
         reload_top_ff <= reload_top_in;
         walk_ff       <= walk_in;
         direct_ff     <= direct_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_group_ff  <= cur_group_in;
      cur_right_ff  <= cur_right_in;
      root_group_ff <= root_group_in;
      root_right_ff <= root_right_in;
      root_sym_ff   <= root_sym_in;
      top_idx_ff    <= top_idx_in;
      pend_addr_ff  <= pend_addr_in;
      pend_val_ff   <= pend_val_in;
      nxt_idx_ff    <= nxt_idx_in;
   end

endmodule

// ===== sv/htld_checker.sv =====
`include "assert_macros.svh"

module htld_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [htld_pkg::SYM_BITS-1:0] rsp_symbol,
   input logic                          rsp_last,
   input logic                          rsp_status,
   input logic                          csr_pready
);

   // register port never inserts wait states
   `ASSERT_IMPLY(a_pready_high, clock, reset, 1'b1, csr_pready)

   // req_ready drops after every accepted bit
   `ASSERT_NEXT(a_two_cycle_slot, clock, reset, req_valid && req_ready, !req_ready)

   // an error result carries no byte and no last flag
   `ASSERT_IMPLY(a_error_shape, clock, reset, rsp_valid && rsp_status, (rsp_symbol == '0) && !rsp_last)

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_symbol) && $stable(rsp_last) && $stable(rsp_status))

endmodule

bind huffman_tree_load_decoder htld_checker u_htld_checker (.*);
